>>> rtl/assert_macros.svh
// Assertion macros shared by the FAT decoder RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset
`define FGC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included
`define FGC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/fgc_pkg.sv
// Types, constants and widths of the FAT geometry and chain decoder
package fgc_pkg;

  // Physical address width; the data address saturates below 2^ADDR_WIDTH
  localparam int ADDR_WIDTH = 32;

  // Field widths
  localparam int ClusterW = 28;
  localparam int RawW     = 32;
  localparam int AddrW    = 32;
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 16;

  // Derived geometry widths
  localparam int BpsW       = 13;
  localparam int SpcW       = 8;
  localparam int FatProdW   = 24;  // fat_count * fat_size
  localparam int RsvdBytesW = 29;  // reserved * bytes per sector
  localparam int StepW      = 21;  // sectors per cluster * bytes per sector
  localparam int SumBaseW   = 25;  // reserved + FAT sectors + root sectors
  localparam int DataStartW = 38;  // sector sum * bytes per sector
  localparam int DivW       = 22;  // dividend of both divisions
  localparam int DivCntW    = 5;
  localparam int RdsW       = 22;  // root-directory sector count
  localparam int MultW      = 49;  // cluster distance * cluster bytes
  localparam int SumW       = 50;  // data address before clamping

  // Largest data address that can be presented
  localparam logic [AddrW-1:0] SatLimit = (ADDR_WIDTH >= AddrW) ? {AddrW{1'b1}}
                                        : AddrW'((64'd1 << ADDR_WIDTH) - 64'd1);

  // Cluster-count limits of the FAT types
  localparam logic [15:0] Fat12Limit = 16'd4085;
  localparam logic [15:0] Fat16Limit = 16'd65525;

  // Chain markers by FAT type
  localparam logic [ClusterW-1:0] Fat12End = 28'h0000FF8;
  localparam logic [ClusterW-1:0] Fat12Bad = 28'h0000FF7;
  localparam logic [ClusterW-1:0] Fat16End = 28'h000FFF8;
  localparam logic [ClusterW-1:0] Fat16Bad = 28'h000FFF7;
  localparam logic [ClusterW-1:0] Fat32End = 28'hFFFFFF8;
  localparam logic [ClusterW-1:0] Fat32Bad = 28'hFFFFFF7;

  typedef enum logic [1:0] {
    FAT12 = 2'd0,
    FAT16 = 2'd1,
    FAT32 = 2'd2
  } fat_kind_t;

  typedef enum logic [1:0] {
    CHAIN_NEXT = 2'd0,
    CHAIN_BAD  = 2'd1,
    CHAIN_END  = 2'd2
  } chain_status_t;

  typedef enum logic [CfgAddrW-1:0] {
    REG_BPS   = 3'd0,
    REG_SPC   = 3'd1,
    REG_RSVD  = 3'd2,
    REG_FATS  = 3'd3,
    REG_ROOTS = 3'd4,
    REG_FATSZ = 3'd5,
    REG_TOTAL = 3'd6
  } cfg_reg_t;

  // Geometry handed from the register block to the lookup pipeline
  typedef struct packed {
    logic                  busy;
    fat_kind_t             kind;
    logic [AddrW-1:0]      root_addr;
    logic [RsvdBytesW-1:0] rsvd_bytes;
    logic [DataStartW-1:0] data_start;
    logic [StepW-1:0]      step;
  } geom_t;

endpackage

>>> rtl/fgc_if.sv
// Handshake channel interfaces of the FAT geometry and chain decoder
interface fgc_cfg_if;
  import fgc_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgAddrW-1:0] addr;
  logic [CfgDataW-1:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

interface fgc_req_if;
  import fgc_pkg::*;
  logic                valid;
  logic                ready;
  logic [ClusterW-1:0] cluster_number;
  logic [RawW-1:0]     raw_entry;
  modport source (output valid, cluster_number, raw_entry, input ready);
  modport sink (input valid, cluster_number, raw_entry, output ready);
endinterface

interface fgc_rsp_if;
  import fgc_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          fat_kind;
  logic [AddrW-1:0]    root_dir_address;
  logic [AddrW-1:0]    fat_entry_address;
  logic [AddrW-1:0]    cluster_data_address;
  logic                address_saturated;
  logic [ClusterW-1:0] next_cluster;
  logic [1:0]          chain_status;
  modport source (
    output valid, fat_kind, root_dir_address, fat_entry_address, cluster_data_address,
           address_saturated, next_cluster, chain_status,
    input  ready
  );
  modport sink (
    input  valid, fat_kind, root_dir_address, fat_entry_address, cluster_data_address,
           address_saturated, next_cluster, chain_status,
    output ready
  );
endinterface

>>> rtl/fgc_geometry.sv
// Boot-sector registers and the sequencer that derives the volume geometry
`include "assert_macros.svh"

module fgc_geometry
  import fgc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  fgc_cfg_if.sink    cfg,
  output geom_t      geom
);

  typedef enum logic [3:0] {
    ST_FATPROD,
    ST_RSVD,
    ST_STEP,
    ST_RDS_DIV,
    ST_USED,
    ST_DSEC,
    ST_CLU_DIV,
    ST_KIND,
    ST_ROOT,
    ST_DATA,
    ST_IDLE
  } state_t;

  state_t state;

  // Boot-sector registers
  logic [BpsW-1:0] bps;
  logic [SpcW-1:0] spc;
  logic [15:0]     rsvd;
  logic [7:0]      fats;
  logic [15:0]     roots;
  logic [15:0]     fatsz;
  logic [15:0]     total;

  // Derived values
  logic [FatProdW-1:0]  fat_prod;
  logic [RsvdBytesW-1:0] rsvd_bytes;
  logic [StepW-1:0]     step;
  logic [SumBaseW-1:0]  base_sum;
  logic [SumBaseW-1:0]  used;
  logic [AddrW-1:0]     root_addr;
  logic [DataStartW-1:0] data_start;
  fat_kind_t            kind;

  // Shared restoring divider
  logic [DivW-1:0]  div_quo;
  logic [BpsW-1:0]  div_rem;
  logic [BpsW-1:0]  div_den;
  logic [DivCntW-1:0] div_cnt;
  logic [BpsW:0]    div_sh;
  logic             div_ge;
  logic [BpsW:0]    div_diff;

  logic [SumBaseW-1:0] rds_ext;
  logic [15:0]         data_sec;
  logic [15:0]         clusters;

  assign cfg.ready = 1'b1;

  // One divider step: shift in the next dividend bit and trial-subtract
  assign div_sh   = {div_rem, div_quo[DivW-1]};
  assign div_ge   = (div_sh >= {1'b0, div_den});
  assign div_diff = div_sh - {1'b0, div_den};

  // Root-directory sector count is zero for a zero sector size
  assign rds_ext  = (bps == '0) ? '0 : SumBaseW'(div_quo[RdsW-1:0]);
  assign data_sec = ({9'd0, total} > used) ? 16'({9'd0, total} - used) : 16'd0;
  assign clusters = (spc == '0) ? 16'd0 : div_quo[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FATPROD;
      bps   <= BpsW'(512);
      spc   <= SpcW'(1);
      rsvd  <= 16'd1;
      fats  <= 8'd2;
      roots <= 16'd512;
      fatsz <= 16'd9;
      total <= 16'd2880;
    end else if (cfg.valid && cfg.ready) begin
      // Take the register write and recompute the geometry from the start
      unique case (cfg_reg_t'(cfg.addr))
        REG_BPS:   bps   <= cfg.data[BpsW-1:0];
        REG_SPC:   spc   <= cfg.data[SpcW-1:0];
        REG_RSVD:  rsvd  <= cfg.data;
        REG_FATS:  fats  <= cfg.data[7:0];
        REG_ROOTS: roots <= cfg.data;
        REG_FATSZ: fatsz <= cfg.data;
        REG_TOTAL: total <= cfg.data;
        default: ;
      endcase
      state <= ST_FATPROD;
    end else begin
      unique case (state)
        ST_FATPROD: begin
          fat_prod <= FatProdW'(fats) * FatProdW'(fatsz);
          state    <= ST_RSVD;
        end
        ST_RSVD: begin
          rsvd_bytes <= RsvdBytesW'(rsvd) * RsvdBytesW'(bps);
          state      <= ST_STEP;
        end
        ST_STEP: begin
          // Load roots*32 + bps - 1 over bps
          step    <= StepW'(spc) * StepW'(bps);
          div_quo <= DivW'({roots, 5'd0}) + DivW'(bps) - DivW'(1);
          div_rem <= '0;
          div_den <= bps;
          div_cnt <= DivCntW'(DivW - 1);
          state   <= ST_RDS_DIV;
        end
        ST_RDS_DIV: begin
          div_rem <= div_ge ? div_diff[BpsW-1:0] : div_sh[BpsW-1:0];
          div_quo <= {div_quo[DivW-2:0], div_ge};
          div_cnt <= div_cnt - DivCntW'(1);
          if (div_cnt == '0) begin
            state <= ST_USED;
          end
        end
        ST_USED: begin
          base_sum <= SumBaseW'(rsvd) + SumBaseW'(fat_prod);
          used     <= SumBaseW'(rsvd) + SumBaseW'(fat_prod) + rds_ext;
          state    <= ST_DSEC;
        end
        ST_DSEC: begin
          // Load data sectors over sectors per cluster
          div_quo <= DivW'(data_sec);
          div_rem <= '0;
          div_den <= BpsW'(spc);
          div_cnt <= DivCntW'(DivW - 1);
          state   <= ST_CLU_DIV;
        end
        ST_CLU_DIV: begin
          div_rem <= div_ge ? div_diff[BpsW-1:0] : div_sh[BpsW-1:0];
          div_quo <= {div_quo[DivW-2:0], div_ge};
          div_cnt <= div_cnt - DivCntW'(1);
          if (div_cnt == '0) begin
            state <= ST_KIND;
          end
        end
        ST_KIND: begin
          if (clusters < Fat12Limit) begin
            kind <= FAT12;
          end else if (clusters < Fat16Limit) begin
            kind <= FAT16;
          end else begin
            kind <= FAT32;
          end
          state <= ST_ROOT;
        end
        ST_ROOT: begin
          root_addr <= AddrW'(DataStartW'(base_sum) * DataStartW'(bps));
          state     <= ST_DATA;
        end
        ST_DATA: begin
          data_start <= DataStartW'(used) * DataStartW'(bps);
          state      <= ST_IDLE;
        end
        ST_IDLE: ;
        default: state <= ST_FATPROD;
      endcase
    end
  end

  // Present the derived geometry
  always_comb begin
    geom.busy       = (state != ST_IDLE);
    geom.kind       = kind;
    geom.root_addr  = root_addr;
    geom.rsvd_bytes = rsvd_bytes;
    geom.data_start = data_start;
    geom.step       = step;
  end

  `FGC_ASSERT(a_spc_zero_fat12, clk, rst, (!geom.busy && spc == '0) |-> (geom.kind == FAT12), "zero sectors per cluster must give FAT12")
  `FGC_ASSERT_ALWAYS(a_cfg_restarts, clk, (cfg.valid && cfg.ready) |=> geom.busy, "register write must restart the geometry sequencer")
  `FGC_ASSERT(a_div_ends, clk, rst, (state == ST_CLU_DIV && div_cnt == '0 && !cfg.valid) |=> (state == ST_KIND), "cluster division must end after its last step")

endmodule

>>> rtl/fat_geometry_and_chain_decoder.sv
// Top level: FAT lookup pipeline that decodes one cluster per cycle while the geometry is idle and rsp is not stalled
//
// channel  dir  modport          payload
// cfg      in   fgc_cfg_if.sink  addr (register index), data
// req      in   fgc_req_if.sink  cluster_number, raw_entry
// rsp      out  fgc_rsp_if.source fat_kind, addresses, next_cluster, chain_status
//
// One lookup per cycle sustained while rsp is ready; a taken beat passes through
// the multiply stage, the add stage and the saturate/output stage in turn.
// Reset and every register write start the geometry sequencer, which runs two
// 22-step restoring divisions; req.ready stays low meanwhile.
// Each stage moves when the one after it is empty or moving, so a stall on
// rsp fills the pipe without losing or repeating a beat.
`include "assert_macros.svh"

module fat_geometry_and_chain_decoder
  import fgc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  fgc_cfg_if.sink    cfg,
  fgc_req_if.sink    req,
  fgc_rsp_if.source  rsp
);

  geom_t geom;

  fgc_geometry u_geometry (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .geom (geom)
  );

  // Stage valids and advance conditions
  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;

  // Stage 1: data offset product, FAT entry address, decoded entry
  logic                neg1;
  logic [MultW-1:0]    mult1;
  logic [AddrW-1:0]    entry1;
  logic [ClusterW-1:0] next1;
  chain_status_t       status1;
  fat_kind_t           kind1;

  // Stage 2: signed data address sum
  logic                neg2;
  logic [SumW:0]       sum2;
  logic [AddrW-1:0]    entry2;
  logic [ClusterW-1:0] next2;
  chain_status_t       status2;
  fat_kind_t           kind2;

  // Stage 3: output register
  logic                neg3;
  logic [AddrW-1:0]    data3;
  logic                sat3;
  logic [AddrW-1:0]    entry3;
  logic [ClusterW-1:0] next3;
  chain_status_t       status3;
  fat_kind_t           kind3;

  // Combinational stage inputs
  logic                low_n;
  logic [ClusterW-1:0] nm2;
  logic [29:0]         entry_off;
  logic [ClusterW-1:0] next_c;
  chain_status_t       status_c;

  assign rdy3      = !v3 || rsp.ready;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign req.ready = rdy1 && !geom.busy;

  // Distance of the cluster from cluster two, with its direction
  assign low_n = (req.cluster_number < ClusterW'(2));
  assign nm2   = low_n ? (ClusterW'(2) - req.cluster_number)
                       : (req.cluster_number - ClusterW'(2));

  // Entry offset and decoded entry by FAT kind
  always_comb begin
    unique case (geom.kind)
      FAT32: begin
        entry_off = {req.cluster_number, 2'b00};
        next_c    = req.raw_entry[ClusterW-1:0];
        if (next_c >= Fat32End) begin
          status_c = CHAIN_END;
        end else if (next_c == Fat32Bad) begin
          status_c = CHAIN_BAD;
        end else begin
          status_c = CHAIN_NEXT;
        end
      end
      FAT16: begin
        entry_off = {1'b0, req.cluster_number, 1'b0};
        next_c    = ClusterW'(req.raw_entry[15:0]);
        if (next_c >= Fat16End) begin
          status_c = CHAIN_END;
        end else if (next_c == Fat16Bad) begin
          status_c = CHAIN_BAD;
        end else begin
          status_c = CHAIN_NEXT;
        end
      end
      default: begin
        entry_off = 30'(req.cluster_number) + 30'(req.cluster_number[ClusterW-1:1]);
        next_c    = req.cluster_number[0] ? ClusterW'(req.raw_entry[15:4])
                                          : ClusterW'(req.raw_entry[11:0]);
        if (next_c >= Fat12End) begin
          status_c = CHAIN_END;
        end else if (next_c == Fat12Bad) begin
          status_c = CHAIN_BAD;
        end else begin
          status_c = CHAIN_NEXT;
        end
      end
    endcase
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= req.valid && req.ready;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
    end
  end

  // Stage 1: multiply the offset, add the entry address, decode the entry
  always_ff @(posedge clk) begin
    if (rdy1) begin
      neg1    <= low_n;
      mult1   <= MultW'(nm2) * MultW'(geom.step);
      entry1  <= AddrW'(geom.rsvd_bytes) + AddrW'(entry_off);
      next1   <= next_c;
      status1 <= status_c;
      kind1   <= geom.kind;
    end
  end

  // Stage 2: add or subtract the offset from the data region start
  always_ff @(posedge clk) begin
    if (rdy2) begin
      neg2    <= neg1;
      sum2    <= neg1 ? ((SumW + 1)'(geom.data_start) - (SumW + 1)'(mult1))
                      : ((SumW + 1)'(geom.data_start) + (SumW + 1)'(mult1));
      entry2  <= entry1;
      next2   <= next1;
      status2 <= status1;
      kind2   <= kind1;
    end
  end

  // Stage 3: clamp below zero and above the address limit
  always_ff @(posedge clk) begin
    if (rdy3) begin
      neg3    <= neg2;
      entry3  <= entry2;
      next3   <= next2;
      status3 <= status2;
      kind3   <= kind2;
      if (neg2 && sum2[SumW]) begin
        data3 <= '0;
        sat3  <= 1'b1;
      end else if (sum2[SumW-1:0] > SumW'(SatLimit)) begin
        data3 <= AddrW'(SatLimit);
        sat3  <= 1'b1;
      end else begin
        data3 <= sum2[AddrW-1:0];
        sat3  <= 1'b0;
      end
    end
  end

  // Drive the result beat
  assign rsp.valid                = v3;
  assign rsp.fat_kind             = kind3;
  assign rsp.root_dir_address     = geom.root_addr;
  assign rsp.fat_entry_address    = entry3;
  assign rsp.cluster_data_address = data3;
  assign rsp.address_saturated    = sat3;
  assign rsp.next_cluster         = next3;
  assign rsp.chain_status         = status3;

  `FGC_ASSERT(a_no_beat_after_cfg, clk, rst, (cfg.valid && cfg.ready) |=> !(req.valid && req.ready), "lookup taken before geometry recompute")
  `FGC_ASSERT(a_zero_clamp_low, clk, rst, (v3 && sat3 && data3 == '0) |-> neg3, "data address clamped to zero for cluster two or above")
  `FGC_ASSERT(a_bad_value, clk, rst, (v3 && status3 == CHAIN_BAD) |-> ((kind3 == FAT12 && next3 == Fat12Bad) || (kind3 == FAT16 && next3 == Fat16Bad) || (kind3 == FAT32 && next3 == Fat32Bad)), "bad-cluster status without the bad marker")

endmodule
